// ===== rtl/hcbd_pkg.sv =====
// Shared types and constants for the chunked body decoder.
package hcbd_pkg;

	// Width of the document size limit register
	localparam int unsigned LIMIT_W = 31;
	// Width of the running body length
	localparam int unsigned COUNT_W = 32;
	// Limit after reset
	localparam logic [LIMIT_W-1:0] LIMIT_RESET = 31'd100000;
	// Default depth of the queue between front and back
	localparam int unsigned QUEUE_DEPTH_DEF = 4;

	// Input operation codes
	localparam logic OP_BYTE  = 1'b0;
	localparam logic OP_BEGIN = 1'b1;

	// Result kinds
	localparam logic KIND_PAYLOAD = 1'b0;
	localparam logic KIND_END     = 1'b1;

	// One classified input word as it travels from front to back
	typedef struct packed {
		logic       op;
		logic [7:0] data_byte;
		logic       is_hex;
		logic [3:0] hex_val;
		logic       is_blank;
		logic       is_cr;
		logic       is_lf;
		logic       is_zero;
		logic       is_x;
	} item_t;

endpackage

// ===== rtl/http_chunked_body_decoder.sv =====
// Top level of the HTTP/1.1 chunked body decoder.
//
// channel   direction  handshake            payload
// input     in         in_valid / in_stall  op, data_byte
// result    out        out_valid / out_stall out_kind, out_byte, body_length, kept_length
// config    in         cfg_valid / cfg_ready cfg_data (max_document_size)
//
// One word a cycle is taken when the result side flows. From input acceptance to result
// a word passes the queue write, then the parser and output register.
// Words with no result pass the parser even while a result waits on out_stall.
// The queue of QUEUE_DEPTH words lets the input run on while the output is stalled.
// Asynchronous active-low reset clears all control state and sets the limit to 100000.
module http_chunked_body_decoder #(
	parameter int unsigned QUEUE_DEPTH = hcbd_pkg::QUEUE_DEPTH_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic                          op,
	input  logic [7:0]                    data_byte,
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic                          out_kind,
	output logic [7:0]                    out_byte,
	output logic [hcbd_pkg::COUNT_W-1:0]  body_length,
	output logic [hcbd_pkg::LIMIT_W-1:0]  kept_length,
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [hcbd_pkg::LIMIT_W-1:0]  cfg_data
);
	import hcbd_pkg::*;

	item_t push_item;
	item_t head;
	logic  push;
	logic  pop;
	logic  head_valid;
	logic  q_full;

	// Limit register always takes a write
	assign cfg_ready = 1'b1;

	hcbd_front u_front (
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.op        (op),
		.data_byte (data_byte),
		.q_full    (q_full),
		.push      (push),
		.push_item (push_item)
	);

	hcbd_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_item  (push_item),
		.pop        (pop),
		.head       (head),
		.head_valid (head_valid),
		.full       (q_full)
	);

	hcbd_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.head        (head),
		.head_valid  (head_valid),
		.pop         (pop),
		.cfg_valid   (cfg_valid && cfg_ready),
		.cfg_data    (cfg_data),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.out_kind    (out_kind),
		.out_byte    (out_byte),
		.body_length (body_length),
		.kept_length (kept_length)
	);

endmodule

// ===== rtl/hcbd_front.sv =====
// Front part: takes input words and classifies each byte for the parser.
module hcbd_front (
	input  logic               in_valid,
	output logic               in_stall,
	input  logic               op,
	input  logic [7:0]         data_byte,
	input  logic               q_full,
	output logic               push,
	output hcbd_pkg::item_t    push_item
);
	import hcbd_pkg::*;

	// Stall while the queue has no room
	assign in_stall = q_full;
	assign push     = in_valid && !q_full;

	// Classify the byte: hex digit, blank, line-end characters, prefix characters
	always_comb begin
		push_item           = '0;
		push_item.op        = op;
		push_item.data_byte = data_byte;
		push_item.is_blank  = (data_byte == 8'h20) || (data_byte >= 8'h09 && data_byte <= 8'h0D);
		push_item.is_cr     = (data_byte == 8'h0D);
		push_item.is_lf     = (data_byte == 8'h0A);
		push_item.is_zero   = (data_byte == 8'h30);
		push_item.is_x      = (data_byte == 8'h78) || (data_byte == 8'h58);
		if (data_byte >= 8'h30 && data_byte <= 8'h39) begin
			push_item.is_hex  = 1'b1;
			push_item.hex_val = data_byte[3:0];
		end else if (data_byte >= 8'h61 && data_byte <= 8'h66) begin
			push_item.is_hex  = 1'b1;
			push_item.hex_val = 4'(data_byte[3:0] + 4'd9);
		end else if (data_byte >= 8'h41 && data_byte <= 8'h46) begin
			push_item.is_hex  = 1'b1;
			push_item.hex_val = 4'(data_byte[3:0] + 4'd9);
		end
	end

endmodule

// ===== rtl/hcbd_queue.sv =====
// Short queue of classified words between front and back.
module hcbd_queue #(
	parameter int unsigned DEPTH = hcbd_pkg::QUEUE_DEPTH_DEF
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            push,
	input  hcbd_pkg::item_t push_item,
	input  logic            pop,
	output hcbd_pkg::item_t head,
	output logic            head_valid,
	output logic            full
);
	import hcbd_pkg::*;

	localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned CNT_W = $clog2(DEPTH + 1);

	item_t             store_q [DEPTH];
	logic [PTR_W-1:0]  wr_ptr_q;
	logic [PTR_W-1:0]  rd_ptr_q;
	logic [CNT_W-1:0]  count_q;

	assign head       = store_q[rd_ptr_q];
	assign head_valid = (count_q != '0);
	assign full       = (count_q == CNT_W'(DEPTH));

	// Write the incoming word
	always_ff @(posedge clk) begin
		if (push) begin
			store_q[wr_ptr_q] <= push_item;
		end
	end

	// Advance pointers and track fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				if (wr_ptr_q == PTR_W'(DEPTH - 1)) begin
					wr_ptr_q <= '0;
				end else begin
					wr_ptr_q <= wr_ptr_q + 1'b1;
				end
			end
			if (pop) begin
				if (rd_ptr_q == PTR_W'(DEPTH - 1)) begin
					rd_ptr_q <= '0;
				end else begin
					rd_ptr_q <= rd_ptr_q + 1'b1;
				end
			end
			case ({push, pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

// ===== rtl/hcbd_back.sv =====
// Back part: size-line parser, chunk counters and the output register.
module hcbd_back (
	input  logic                            clk,
	input  logic                            arst_n,
	input  hcbd_pkg::item_t                 head,
	input  logic                            head_valid,
	output logic                            pop,
	input  logic                            cfg_valid,
	input  logic [hcbd_pkg::LIMIT_W-1:0]    cfg_data,
	output logic                            out_valid,
	input  logic                            out_stall,
	output logic                            out_kind,
	output logic [7:0]                      out_byte,
	output logic [hcbd_pkg::COUNT_W-1:0]    body_length,
	output logic [hcbd_pkg::LIMIT_W-1:0]    kept_length
);
	import hcbd_pkg::*;

	// Parser phases
	localparam logic [2:0] PH_LEAD   = 3'd0;
	localparam logic [2:0] PH_ZERO   = 3'd1;
	localparam logic [2:0] PH_DIGITS = 3'd2;
	localparam logic [2:0] PH_REST   = 3'd3;
	localparam logic [2:0] PH_DATA   = 3'd4;
	localparam logic [2:0] PH_TAIL   = 3'd5;
	localparam logic [2:0] PH_DONE   = 3'd6;

	logic [LIMIT_W-1:0] limit_q;
	logic [2:0]         phase_q, phase_d;
	logic               cr_q, cr_d;
	logic [COUNT_W-1:0] accum_q, accum_d;
	logic [COUNT_W-1:0] left_q, left_d;
	logic [COUNT_W-1:0] total_q, total_d;
	logic [LIMIT_W-1:0] kept_q, kept_d;
	logic               emit, emit_kind;
	logic               line_end;
	logic               out_free;

	logic               out_valid_q;
	logic               out_kind_q;
	logic [7:0]         out_byte_q;
	logic [COUNT_W-1:0] body_length_q;
	logic [LIMIT_W-1:0] kept_length_q;

	assign line_end = cr_q && head.is_lf;

	// Work out the next state and any result for the head word
	always_comb begin
		phase_d   = phase_q;
		cr_d      = cr_q;
		accum_d   = accum_q;
		left_d    = left_q;
		total_d   = total_q;
		kept_d    = kept_q;
		emit      = 1'b0;
		emit_kind = KIND_PAYLOAD;
		if (head.op == OP_BEGIN) begin
			phase_d = PH_LEAD;
			cr_d    = 1'b0;
			accum_d = '0;
			left_d  = '0;
			total_d = '0;
			kept_d  = '0;
		end else begin
			case (phase_q)
				PH_DONE: begin
					phase_d = PH_DONE;
				end
				PH_DATA: begin
					total_d = total_q + 1'b1;
					if (kept_q < limit_q) begin
						kept_d = kept_q + 1'b1;
						emit   = 1'b1;
					end
					left_d = left_q - 1'b1;
					if (left_q == COUNT_W'(1)) begin
						phase_d = PH_TAIL;
						cr_d    = 1'b0;
					end
				end
				PH_TAIL: begin
					cr_d = head.is_cr;
					if (line_end) begin
						phase_d = PH_LEAD;
						accum_d = '0;
						cr_d    = 1'b0;
					end
				end
				default: begin
					cr_d = head.is_cr;
					if (line_end) begin
						cr_d = 1'b0;
						if (accum_q == '0) begin
							phase_d   = PH_DONE;
							emit      = 1'b1;
							emit_kind = KIND_END;
						end else begin
							left_d  = accum_q;
							phase_d = PH_DATA;
						end
					end else begin
						case (phase_q)
							PH_LEAD: begin
								if (head.is_zero) begin
									phase_d = PH_ZERO;
								end else if (head.is_hex) begin
									accum_d = COUNT_W'(head.hex_val);
									phase_d = PH_DIGITS;
								end else if (!head.is_blank) begin
									phase_d = PH_REST;
								end
							end
							PH_ZERO: begin
								if (head.is_x) begin
									phase_d = PH_DIGITS;
								end else if (head.is_hex) begin
									accum_d = {accum_q[COUNT_W-5:0], head.hex_val};
									phase_d = PH_DIGITS;
								end else begin
									phase_d = PH_REST;
								end
							end
							PH_DIGITS: begin
								if (head.is_hex) begin
									accum_d = {accum_q[COUNT_W-5:0], head.hex_val};
								end else begin
									phase_d = PH_REST;
								end
							end
							default: begin
								phase_d = phase_q;
							end
						endcase
					end
				end
			endcase
		end
	end

	// Take the head word unless it has a result and the output is still full
	assign out_free = !out_valid_q || !out_stall;
	assign pop      = head_valid && (!emit || out_free);

	// Hold the document size limit
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			limit_q <= LIMIT_RESET;
		end else if (cfg_valid) begin
			limit_q <= cfg_data;
		end
	end

	// Advance parser state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_LEAD;
			cr_q    <= 1'b0;
			accum_q <= '0;
			left_q  <= '0;
			total_q <= '0;
			kept_q  <= '0;
		end else if (pop) begin
			phase_q <= phase_d;
			cr_q    <= cr_d;
			accum_q <= accum_d;
			left_q  <= left_d;
			total_q <= total_d;
			kept_q  <= kept_d;
		end
	end

	// Output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_free) begin
			out_valid_q <= pop && emit;
		end
	end

	// Load the result word
	always_ff @(posedge clk) begin
		if (pop && emit) begin
			out_kind_q    <= emit_kind;
			out_byte_q    <= (emit_kind == KIND_END) ? 8'd0 : head.data_byte;
			body_length_q <= total_d;
			kept_length_q <= kept_d;
		end
	end

	assign out_valid   = out_valid_q;
	assign out_kind    = out_kind_q;
	assign out_byte    = out_byte_q;
	assign body_length = body_length_q;
	assign kept_length = kept_length_q;

endmodule

// ===== rtl/hcbd_checker.sv =====
// Port-level assertions for the chunked body decoder, bound to the top level.
module hcbd_checker (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          out_valid,
	input logic                          out_stall,
	input logic                          out_kind,
	input logic [7:0]                    out_byte,
	input logic [hcbd_pkg::COUNT_W-1:0]  body_length,
	input logic [hcbd_pkg::LIMIT_W-1:0]  kept_length
);
	import hcbd_pkg::*;

	// Hold a stalled result word
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid)
		else $error("result word dropped while stalled");

	// Keep a stalled result word unchanged
	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> $stable(out_kind) && $stable(out_byte)
			&& $stable(body_length) && $stable(kept_length))
		else $error("stalled result word changed");

	// End word carries a zero byte
	a_end_byte: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (out_kind == KIND_END) |-> out_byte == 8'd0)
		else $error("end word with non-zero byte");

	// A delivered byte has been counted as kept
	a_kept_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (out_kind == KIND_PAYLOAD) |-> kept_length != '0)
		else $error("payload word with zero kept length");

	// A presented result word is fully defined
	a_out_known: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> !$isunknown({out_kind, out_byte, body_length, kept_length}))
		else $error("result word with unknown bits");

endmodule

bind http_chunked_body_decoder hcbd_checker u_hcbd_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.out_valid   (out_valid),
	.out_stall   (out_stall),
	.out_kind    (out_kind),
	.out_byte    (out_byte),
	.body_length (body_length),
	.kept_length (kept_length)
);
